### rtl/smf_pkg.sv
`timescale 1ns / 1ps

package smf_pkg;

    localparam int WINDOW_LEN  = 5;
    localparam int CENTRE_IDX  = WINDOW_LEN / 2;
    localparam int FILL_W      = $clog2(WINDOW_LEN + 1);
    localparam int RANK_W      = $clog2(WINDOW_LEN);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [31:0] value_t;
    typedef logic        [31:0] stamp_t;
    typedef logic        [31:0] count_t;

    typedef struct packed {
        value_t sample_value;
        stamp_t sample_time;
        logic   end_of_series;
    } sample_t;

    typedef struct packed {
        value_t median_value;
        stamp_t centre_time;
        count_t result_count;
    } result_t;

    // one full window handed from the front to the back
    typedef struct packed {
        value_t [WINDOW_LEN-1:0] values;
        stamp_t                  centre_time;
        count_t                  result_count;
    } job_t;

    // precedes[i][j]: entry j sorts ahead of entry i (ties broken by position)
    typedef logic [WINDOW_LEN-1:0][WINDOW_LEN-1:0] order_t;

endpackage

### rtl/sliding_median_filter_unit.sv
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// sample    in         push / full          sample_t (value, time, end of series)
// result    out        empty / pop          result_t (median, centre time, count)
//
// One sample per clock sustained while full stays low; a result reaches the ports
// through the queue entry written at the transfer, the pair-compare stage and
// the rank/select into the result register.
// Reset clears window fill level, result count, queue and pipeline valids.
// A two-entry queue separates the window front from the median pipeline;
// full rises only when that queue is full and the pipeline is stalled by a low pop.

module sliding_median_filter_unit
    import smf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  sample_t sample,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic accept;
    logic job_push;
    job_t new_job;
    job_t head_job;
    logic q_empty;
    logic job_pop;

    assign accept = push && !full;

    smf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .sample   (sample),
        .job_push (job_push),
        .job      (new_job)
    );

    smf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (new_job),
        .pop      (job_pop),
        .full     (full),
        .empty    (q_empty),
        .head     (head_job)
    );

    smf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job       (head_job),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

### rtl/smf_front.sv
`timescale 1ns / 1ps

module smf_front
    import smf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  sample_t sample,
    output logic    job_push,
    output job_t    job
);

    value_t [WINDOW_LEN-1:0] value_win_reg, value_win_next;
    stamp_t [WINDOW_LEN-1:0] time_win_reg, time_win_next;
    logic   [FILL_W-1:0]     fill_reg, fill_next;
    count_t                  count_reg, count_next;
    count_t                  count_inc;
    logic                    window_full;
    logic                    window_ready;

    // window shifts on every accepted sample; newest entry sits at the top index
    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN - 1; i++)
        begin
            value_win_next[i] = value_win_reg[i+1];
            time_win_next[i]  = time_win_reg[i+1];
        end
        value_win_next[WINDOW_LEN-1] = sample.sample_value;
        time_win_next[WINDOW_LEN-1]  = sample.sample_time;
    end

    // the window is complete once this transfer lands in it
    assign window_full  = (fill_reg == FILL_W'(WINDOW_LEN));
    assign window_ready = (fill_reg >= FILL_W'(WINDOW_LEN - 1));
    assign count_inc    = count_reg + 32'd1;
    assign job_push     = accept && window_ready;

    always_comb
    begin
        fill_next  = fill_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (!window_full)
                fill_next = fill_reg + FILL_W'(1);
            if (window_ready)
                count_next = count_inc;
            // flagged sample still yields its result, then the series clears
            if (sample.end_of_series)
            begin
                fill_next  = '0;
                count_next = '0;
            end
        end
    end

    assign job.values       = value_win_next;
    assign job.centre_time  = time_win_next[CENTRE_IDX];
    assign job.result_count = count_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_win_reg <= value_win_next;
            time_win_reg  <= time_win_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW_LEN))
        else $error("window fill level beyond window length");

    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && sample.end_of_series |=> fill_reg == '0 && count_reg == '0)
        else $error("end of series did not clear the window");

endmodule

### rtl/smf_queue.sv
`timescale 1ns / 1ps

module smf_queue
    import smf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic empty,
    output job_t head
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("transfer pushed into a full queue");

endmodule

### rtl/smf_back.sv
`timescale 1ns / 1ps

module smf_back
    import smf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    input  job_t    job,
    output logic    job_pop,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    // stage 1: pairwise order matrix
    logic                    s1_valid_reg;
    value_t [WINDOW_LEN-1:0] s1_values_reg;
    order_t                  s1_order_reg, s1_order_next;
    stamp_t                  s1_time_reg;
    count_t                  s1_count_reg;

    // stage 2: result register
    logic    out_valid_reg;
    result_t out_reg, out_next;

    logic                  out_load, s1_load;
    logic [WINDOW_LEN-1:0] sel;
    logic [RANK_W-1:0]     rank [WINDOW_LEN];
    value_t                median;

    assign out_load = s1_valid_reg && (!out_valid_reg || pop);
    assign s1_load  = !s1_valid_reg || out_load;
    assign job_pop  = job_valid && s1_load;

    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            for (int j = 0; j < WINDOW_LEN; j++)
            begin
                if (j == i)
                    s1_order_next[i][j] = 1'b0;
                else if (j < i)
                    s1_order_next[i][j] = (job.values[j] <= job.values[i]);
                else
                    s1_order_next[i][j] = (job.values[j] < job.values[i]);
            end
        end
    end

    // rank of each entry; exactly one entry holds the centre rank
    always_comb
    begin
        median = '0;
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW_LEN; j++)
                rank[i] = rank[i] + RANK_W'(s1_order_reg[i][j]);
            sel[i] = (rank[i] == RANK_W'(CENTRE_IDX));
            if (sel[i])
                median = median | s1_values_reg[i];
        end
    end

    always_comb
    begin
        out_next.median_value = median;
        out_next.centre_time  = s1_time_reg;
        out_next.result_count = s1_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= job_valid;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            s1_values_reg <= job.values;
            s1_order_reg  <= s1_order_next;
            s1_time_reg   <= job.centre_time;
            s1_count_reg  <= job.result_count;
        end
        if (out_load)
            out_reg <= out_next;
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    a_one_median: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $onehot(sel))
        else $error("median select is not one-hot");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(out_reg))
        else $error("waiting result changed before transfer");

endmodule

### test/smf_checker.sv
`timescale 1ns / 1ps

module smf_checker
    import smf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  logic    full,
    input  sample_t sample,
    input  logic    empty,
    input  logic    pop,
    input  result_t result,
    output int      errors,
    output int      pending
);

    value_t  win_values [WINDOW_LEN];
    stamp_t  win_stamps [WINDOW_LEN];
    int      fill_level;
    count_t  series_count;
    result_t medians_due [$];

    // insertion sort on signed values, pick the middle rank
    function automatic value_t median_of_window();
        value_t ordered [WINDOW_LEN];
        value_t key;
        int     i;
        int     j;
        ordered = win_values;
        for (i = 1; i < WINDOW_LEN; i++)
        begin
            key = ordered[i];
            j   = i - 1;
            while (j >= 0 && ordered[j] > key)
            begin
                ordered[j + 1] = ordered[j];
                j--;
            end
            ordered[j + 1] = key;
        end
        return ordered[WINDOW_LEN / 2];
    endfunction

    task automatic take_sample(input sample_t s);
        result_t due;
        int      i;
        if (fill_level < WINDOW_LEN)
        begin
            win_values[fill_level] = s.sample_value;
            win_stamps[fill_level] = s.sample_time;
            fill_level++;
        end
        else
        begin
            for (i = 0; i < WINDOW_LEN - 1; i++)
            begin
                win_values[i] = win_values[i + 1];
                win_stamps[i] = win_stamps[i + 1];
            end
            win_values[WINDOW_LEN - 1] = s.sample_value;
            win_stamps[WINDOW_LEN - 1] = s.sample_time;
        end
        if (fill_level >= WINDOW_LEN)
        begin
            series_count      = series_count + 1'b1;
            due.median_value  = median_of_window();
            due.centre_time   = win_stamps[CENTRE_IDX];
            due.result_count  = series_count;
            medians_due.push_back(due);
        end
        // result for the flagged sample goes out first, then the series clears
        if (s.end_of_series)
        begin
            fill_level   = 0;
            series_count = '0;
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (medians_due.size() == 0)
        begin
            $error("unexpected result: median_value %0d, centre_time %0d, result_count %0d",
                   got.median_value, got.centre_time, got.result_count);
            errors++;
            return;
        end
        want = medians_due.pop_front();
        if (got.median_value !== want.median_value)
        begin
            $error("median_value: expected %0d, actual %0d",
                   want.median_value, got.median_value);
            errors++;
        end
        if (got.centre_time !== want.centre_time)
        begin
            $error("centre_time: expected %0d, actual %0d",
                   want.centre_time, got.centre_time);
            errors++;
        end
        if (got.result_count !== want.result_count)
        begin
            $error("result_count: expected %0d, actual %0d",
                   want.result_count, got.result_count);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            fill_level   = 0;
            series_count = '0;
            medians_due.delete();
        end
        else
        begin
            if (pop && !empty)
                check_result(result);
            if (push && !full)
                take_sample(sample);
        end
        pending = medians_due.size();
    end

endmodule

### test/tb_sliding_median_filter_unit.sv
`timescale 1ns / 1ps

module tb_sliding_median_filter_unit;
    import smf_pkg::*;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     DRAIN_CYCLES   = 12;
    localparam int     RANDOM_ITEMS   = 730;
    localparam int     CALM_ITEMS     = 120;
    localparam value_t VALUE_MIN      = 32'h8000_0000;
    localparam value_t VALUE_MAX      = 32'h7FFF_FFFF;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    push;
    logic    full;
    sample_t sample;
    logic    empty;
    logic    pop;
    result_t result;

    int      errors;
    int      pending;
    int      stall_cycles = 0;
    bit      idle_on = 1'b0;
    stamp_t  stamp_now;

    always #4 clk = ~clk;

    sliding_median_filter_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .sample (sample),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    smf_checker i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .sample  (sample),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .errors  (errors),
        .pending (pending)
    );

    // result side: random stall bursts while idling is on
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_sample(input value_t v, input stamp_t t, input logic last);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            push   <= 1'b0;
            sample <= sample_t'({$urandom, $urandom, 1'b1});
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        push   <= 1'b1;
        sample <= sample_t'{v, t, last};
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    function automatic value_t pick_value(input int flavor);
        case (flavor)
            0: return value_t'($urandom_range(0, 8)) - 4;
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return VALUE_MIN;
                    1: return VALUE_MAX;
                    2: return '0;
                    3: return -1;
                    default: return value_t'($urandom);
                endcase
            end
            default: return value_t'($urandom);
        endcase
    endfunction

    task automatic send_series(input int len, input int flavor);
        value_t v;
        stamp_t t;
        int     i;
        for (i = 0; i < len; i++)
        begin
            v = pick_value(flavor);
            if ($urandom_range(0, 7) == 0)
                t = $urandom;
            else
            begin
                stamp_now = stamp_now + $urandom_range(1, 100);
                t = stamp_now;
            end
            send_sample(v, t, i == len - 1);
        end
    endtask

    initial
    begin
        int sent;
        int len;
        int i;
        push      = 1'b0;
        sample    = '0;
        stamp_now = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extremes of value and time, window slides, then end of series
        send_sample(VALUE_MIN, '0, 1'b0);
        send_sample(VALUE_MAX, '1, 1'b0);
        send_sample('0, 32'd1, 1'b0);
        send_sample(-1, 32'h8000_0000, 1'b0);
        send_sample(1, 32'h7FFF_FFFF, 1'b0);
        send_sample(VALUE_MAX, 32'd2, 1'b0);
        send_sample(VALUE_MIN, 32'd3, 1'b1);
        // series that ends before the window fills
        send_sample(32'sd100, 32'd10, 1'b0);
        send_sample(-32'sd100, 32'd11, 1'b0);
        send_sample(32'sd7, 32'd12, 1'b1);
        // one-sample series
        send_sample(-5, 32'd20, 1'b1);
        idle_on = 1'b1;
        // all values equal
        for (i = 0; i < 6; i++)
            send_sample(32'sh0001_2345, 32'd30 + i, i == 5);
        // descending window
        for (i = 0; i < 5; i++)
            send_sample(VALUE_MAX - i, 32'd40 + i, i == 4);
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            idle_on = (sent < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0)
                len = $urandom_range(1, 4);
            else
                len = $urandom_range(5, 40);
            send_series(len, $urandom_range(0, 3));
            sent += len;
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        idle_on = 1'b0;
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/smf_pkg.sv
rtl/smf_front.sv
rtl/smf_queue.sv
rtl/smf_back.sv
rtl/sliding_median_filter_unit.sv
test/smf_checker.sv
test/tb_sliding_median_filter_unit.sv
